// ===== src/wsi_pkg.sv =====
// Package for the whitespace stack interpreter: result kinds, symbol codes,
// command codes and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package wsi_pkg;

  // Parameter defaults.
  localparam int STACK_DEPTH_DEF     = 512;
  localparam int MAX_CMD_SYMBOLS_DEF = 4;

  // Source bytes that carry a symbol; every other byte is a comment.
  localparam logic [7:0] BYTE_TAB   = 8'd9;
  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] BYTE_SPACE = 8'd32;

  // Symbol codes, two bits per symbol in the command shift register.
  typedef enum logic [1:0] {
    SYM_SPACE = 2'd0,
    SYM_TAB   = 2'd1,
    SYM_LF    = 2'd2
  } sym_t;

  // Command codes, newest symbol in the lowest two bits.
  localparam int CODE_PUSH    = 0;   // SPACE SPACE
  localparam int LEN_PUSH     = 2;
  localparam int CODE_OUT_NUM = 97;  // TAB LF SPACE TAB
  localparam int CODE_OUT_CHR = 96;  // TAB LF SPACE SPACE
  localparam int LEN_OUT      = 4;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_NUMBER  = 3'd0,
    KIND_CHAR    = 3'd1,
    KIND_UNDER   = 3'd2,
    KIND_OVER    = 3'd3,
    KIND_UNKNOWN = 3'd4
  } kind_t;

endpackage

// ===== src/whitespace_stack_interpreter.sv =====
// Top level of the whitespace stack interpreter: input register, command
// decode, value stack memory and result register. Depends on wsi_pkg.
`timescale 1ns / 1ps

//  Channel  | Ports                                  | Direction
//  ---------+----------------------------------------+----------
//  input    | in_valid, in_ready, in_src_byte[7:0]   | in
//  result   | out_valid, out_ready, out_kind[2:0],   | out
//           | out_value[31:0] (signed)               |
//
// One source byte is taken in every cycle unless a stalled result holds the
// input register. A byte's result passes through the input register and the
// result register, which is loaded together with the registered stack read.
// Synchronous active-low reset empties the stack and clears the command
// decoder; the stack contents are not cleared. A stalled result holds both
// stages, and the input side keeps accepting while the input register is free.

module whitespace_stack_interpreter #(
  parameter int STACK_DEPTH     = wsi_pkg::STACK_DEPTH_DEF,
  parameter int MAX_CMD_SYMBOLS = wsi_pkg::MAX_CMD_SYMBOLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_src_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic signed [31:0] out_value
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CMD_W = 2 * MAX_CMD_SYMBOLS;
  localparam int LEN_W = $clog2(MAX_CMD_SYMBOLS + 1);

  // Pipeline registers.
  logic              a_valid_r;
  logic [7:0]        a_byte_r;
  logic              out_valid_r, out_valid_nxt;
  wsi_pkg::kind_t    kind_r, kind_nxt;
  logic              from_mem_r, from_mem_nxt;
  logic              as_char_r, as_char_nxt;
  logic [31:0]       rd_r;

  // Interpreter state.
  logic              in_arg_r, in_arg_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              arg_started_r, arg_started_nxt;
  logic              arg_neg_r, arg_neg_nxt;
  logic [31:0]       arg_mag_r, arg_mag_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // Stack memory and its access controls.
  logic [31:0]       stack_mem [STACK_DEPTH];
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [31:0]       wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  // Decode helpers.
  logic              adv;
  logic              a_fire;
  logic              is_sym;
  wsi_pkg::sym_t     sym;
  logic [CMD_W-1:0]  cmd_shift;
  logic [LEN_W-1:0]  len_inc;
  logic [CNT_W-1:0]  count_dec;

  // The result register moves when it is empty or being taken.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !a_valid_r || adv;
  assign a_fire   = a_valid_r && adv;

  // Classify the byte held in the input register.
  always_comb begin
    is_sym = 1'b1;
    sym    = wsi_pkg::SYM_SPACE;
    unique case (a_byte_r)
      wsi_pkg::BYTE_SPACE: sym = wsi_pkg::SYM_SPACE;
      wsi_pkg::BYTE_TAB:   sym = wsi_pkg::SYM_TAB;
      wsi_pkg::BYTE_LF:    sym = wsi_pkg::SYM_LF;
      default:             is_sym = 1'b0;
    endcase
  end

  assign cmd_shift = {cmd_r[CMD_W-3:0], sym};
  assign len_inc   = len_r + LEN_W'(1);
  assign count_dec = count_r - CNT_W'(1);

  // Interpreter next state, stack access and result for one item.
  always_comb begin
    in_arg_nxt      = in_arg_r;
    cmd_nxt         = cmd_r;
    len_nxt         = len_r;
    arg_started_nxt = arg_started_r;
    arg_neg_nxt     = arg_neg_r;
    arg_mag_nxt     = arg_mag_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    kind_nxt        = kind_r;
    from_mem_nxt    = from_mem_r;
    as_char_nxt     = as_char_r;
    wr_en           = 1'b0;
    wr_addr         = count_r[AW-1:0];
    wr_data         = arg_neg_r ? (32'd0 - arg_mag_r) : arg_mag_r;
    rd_en           = 1'b0;
    rd_addr         = count_dec[AW-1:0];

    if (adv) begin
      out_valid_nxt = 1'b0;
    end

    if (a_fire && is_sym) begin
      if (in_arg_r) begin
        if (sym == wsi_pkg::SYM_LF) begin
          // End of argument: push the value (overflow if full) and return to command decode.
          in_arg_nxt      = 1'b0;
          cmd_nxt         = '0;
          len_nxt         = '0;
          arg_started_nxt = 1'b0;
          arg_neg_nxt     = 1'b0;
          arg_mag_nxt     = '0;
          if (count_r >= CNT_W'(STACK_DEPTH)) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = wsi_pkg::KIND_OVER;
            from_mem_nxt  = 1'b0;
            as_char_nxt   = 1'b0;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end else if (!arg_started_r) begin
          // The first argument symbol is the sign.
          arg_started_nxt = 1'b1;
          arg_neg_nxt     = (sym == wsi_pkg::SYM_TAB);
        end else begin
          arg_mag_nxt = {arg_mag_r[30:0], sym == wsi_pkg::SYM_TAB};
        end
      end else begin
        cmd_nxt = cmd_shift;
        len_nxt = len_inc;
        if (len_inc == LEN_W'(wsi_pkg::LEN_PUSH) && cmd_shift == CMD_W'(wsi_pkg::CODE_PUSH)) begin
          in_arg_nxt      = 1'b1;
          cmd_nxt         = '0;
          len_nxt         = '0;
          arg_started_nxt = 1'b0;
          arg_neg_nxt     = 1'b0;
          arg_mag_nxt     = '0;
        end else if (len_inc == LEN_W'(wsi_pkg::LEN_OUT) &&
                     (cmd_shift == CMD_W'(wsi_pkg::CODE_OUT_NUM) ||
                      cmd_shift == CMD_W'(wsi_pkg::CODE_OUT_CHR))) begin
          // Pop for output; an empty stack reports underflow.
          cmd_nxt       = '0;
          len_nxt       = '0;
          out_valid_nxt = 1'b1;
          as_char_nxt   = (cmd_shift == CMD_W'(wsi_pkg::CODE_OUT_CHR));
          if (count_r == '0) begin
            kind_nxt     = wsi_pkg::KIND_UNDER;
            from_mem_nxt = 1'b0;
          end else begin
            kind_nxt     = as_char_nxt ? wsi_pkg::KIND_CHAR : wsi_pkg::KIND_NUMBER;
            from_mem_nxt = 1'b1;
            rd_en        = 1'b1;
            count_nxt    = count_dec;
          end
        end else if (len_inc >= LEN_W'(MAX_CMD_SYMBOLS)) begin
          // A full command that matches nothing is dropped and reported as unknown.
          cmd_nxt       = '0;
          len_nxt       = '0;
          out_valid_nxt = 1'b1;
          kind_nxt      = wsi_pkg::KIND_UNKNOWN;
          from_mem_nxt  = 1'b0;
          as_char_nxt   = 1'b0;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      in_arg_r      <= 1'b0;
      cmd_r         <= '0;
      len_r         <= '0;
      arg_started_r <= 1'b0;
      arg_neg_r     <= 1'b0;
      arg_mag_r     <= '0;
      count_r       <= '0;
    end else begin
      if (in_ready) begin
        a_valid_r <= in_valid;
      end
      out_valid_r   <= out_valid_nxt;
      in_arg_r      <= in_arg_nxt;
      cmd_r         <= cmd_nxt;
      len_r         <= len_nxt;
      arg_started_r <= arg_started_nxt;
      arg_neg_r     <= arg_neg_nxt;
      arg_mag_r     <= arg_mag_nxt;
      count_r       <= count_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_byte_r <= in_src_byte;
    end
    kind_r     <= kind_nxt;
    from_mem_r <= from_mem_nxt;
    as_char_r  <= as_char_nxt;
  end

  // Stack memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= stack_mem[rd_addr];
    end
  end

  // Result outputs.
  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_value = !from_mem_r ? 32'sd0 :
                     as_char_r   ? $signed({24'd0, rd_r[7:0]}) : $signed(rd_r);

endmodule

// ===== tb/tb_whitespace_stack_interpreter.sv =====
// Self-checking testbench for whitespace_stack_interpreter: a byte-stream driver,
// a result monitor and an interpreter predictor. Depends on wsi_pkg and the RTL.
`timescale 1ns / 1ps

module tb_whitespace_stack_interpreter;

  localparam int DEPTH      = wsi_pkg::STACK_DEPTH_DEF;
  localparam int MAX_SYMS   = wsi_pkg::MAX_CMD_SYMBOLS_DEF;
  localparam int QUIET_MAX  = 2000;
  localparam int MIX_SYMS   = 300;

  typedef struct packed {
    wsi_pkg::kind_t kind;
    logic [31:0]    value;
  } ws_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_src_byte;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_kind;
  logic signed [31:0] out_value;

  // Source bytes waiting to be sent, and results the interpreter still owes.
  logic [7:0]  src_q[$];
  ws_result_t  results_due[$];

  int n_errors = 0;
  int n_bytes = 0;
  int n_syms = 0;
  int kind_seen[5] = '{default: 0};
  int cyc_cnt = 0;
  int quiet_cycles = 0;

  // Generator state.
  int est_depth;
  int comment_pct;

  // Predictor state.
  logic        arg_active;
  logic [15:0] cmd_sym;
  int          cmd_len;
  logic        arg_sign_seen;
  logic        arg_neg;
  logic [31:0] arg_mag;
  logic [31:0] stack_mem[DEPTH];
  int          stack_fill;

  whitespace_stack_interpreter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_src_byte(in_src_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_value(out_value)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Both sides idle about 8 percent of the time, except in one window where they never idle.
  function automatic int idle_pct();
    return (cyc_cnt >= 1200 && cyc_cnt < 2400) ? 0 : 8;
  endfunction

  // A byte that is not TAB, LF or SPACE.
  function automatic logic [7:0] comment_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == wsi_pkg::BYTE_TAB || b == wsi_pkg::BYTE_LF || b == wsi_pkg::BYTE_SPACE);
    return b;
  endfunction

  // Queue one symbol byte, sometimes preceded by a comment byte.
  task automatic put_sym(input logic [7:0] b);
    if ($urandom_range(0, 99) < comment_pct) src_q.push_back(comment_byte());
    src_q.push_back(b);
    n_syms++;
  endtask

  // Push command: SPACE SPACE, then if with_sign a sign and ndig digits MSB first, LF.
  task automatic gen_push(input bit with_sign, input bit neg, input int ndig,
                          input logic [63:0] digits);
    put_sym(wsi_pkg::BYTE_SPACE);
    put_sym(wsi_pkg::BYTE_SPACE);
    if (with_sign) begin
      put_sym(neg ? wsi_pkg::BYTE_TAB : wsi_pkg::BYTE_SPACE);
      for (int i = ndig - 1; i >= 0; i--)
        put_sym(digits[i] ? wsi_pkg::BYTE_TAB : wsi_pkg::BYTE_SPACE);
    end
    put_sym(wsi_pkg::BYTE_LF);
    est_depth = (est_depth < DEPTH) ? est_depth + 1 : DEPTH;
  endtask

  // Pop command: TAB LF SPACE, then TAB for a number or SPACE for a character.
  task automatic gen_pop(input bit as_char);
    put_sym(wsi_pkg::BYTE_TAB);
    put_sym(wsi_pkg::BYTE_LF);
    put_sym(wsi_pkg::BYTE_SPACE);
    put_sym(as_char ? wsi_pkg::BYTE_SPACE : wsi_pkg::BYTE_TAB);
    if (est_depth > 0) est_depth--;
  endtask

  // Four symbols that form no command.
  task automatic gen_unknown();
    logic [7:0] syms[4];
    int r;
    r = $urandom_range(0, 3);
    case (r)
      0: syms = '{wsi_pkg::BYTE_TAB, wsi_pkg::BYTE_TAB, wsi_pkg::BYTE_TAB,
                  wsi_pkg::BYTE_TAB};
      1: syms = '{wsi_pkg::BYTE_LF, wsi_pkg::BYTE_LF, wsi_pkg::BYTE_LF,
                  wsi_pkg::BYTE_LF};
      2: syms = '{wsi_pkg::BYTE_SPACE, wsi_pkg::BYTE_TAB, wsi_pkg::BYTE_LF,
                  wsi_pkg::BYTE_SPACE};
      default: syms = '{wsi_pkg::BYTE_TAB, wsi_pkg::BYTE_LF, wsi_pkg::BYTE_SPACE,
                        wsi_pkg::BYTE_LF};
    endcase
    foreach (syms[i]) put_sym(syms[i]);
  endtask

  // A push with a random argument: mostly short, some near or past 32 digits.
  task automatic gen_random_push();
    logic [63:0] digits;
    int r;
    int ndig;
    r = $urandom_range(0, 99);
    if (r < 60) ndig = $urandom_range(0, 6);
    else if (r < 85) ndig = $urandom_range(7, 16);
    else if (r < 95) ndig = $urandom_range(28, 33);
    else ndig = $urandom_range(34, 48);
    r = $urandom_range(0, 99);
    if (r < 10) digits = '1;
    else if (r < 15) digits = '0;
    else digits = {$urandom, $urandom};
    gen_push($urandom_range(0, 19) != 0, $urandom_range(0, 1), ndig, digits);
  endtask

  // One random command, leaning toward pops when the stack gets deep.
  task automatic gen_random_command(input int pop_bias);
    int r;
    int junk_len;
    r = $urandom_range(0, 99);
    if (r < 40 - pop_bias) begin
      gen_random_push();
    end else if (r < 70) begin
      gen_pop(1'b0);
    end else if (r < 88) begin
      gen_pop(1'b1);
    end else if (r < 93) begin
      gen_unknown();
    end else begin
      // Broken sequence of arbitrary symbols and comments.
      junk_len = $urandom_range(1, 6);
      repeat (junk_len) begin
        r = $urandom_range(0, 3);
        case (r)
          0: put_sym(wsi_pkg::BYTE_SPACE);
          1: put_sym(wsi_pkg::BYTE_TAB);
          2: put_sym(wsi_pkg::BYTE_LF);
          default: src_q.push_back(comment_byte());
        endcase
      end
    end
  endtask

  // Clear the command decoder and argument collector.
  function automatic void clear_decoder();
    arg_active    = 1'b0;
    cmd_sym       = '0;
    cmd_len       = 0;
    arg_sign_seen = 1'b0;
    arg_neg       = 1'b0;
    arg_mag       = '0;
  endfunction

  // Interpret one accepted source byte and record the result it owes, if any.
  task automatic interpret_byte(input logic [7:0] b);
    wsi_pkg::sym_t s;
    logic [31:0]   v;
    if (b == wsi_pkg::BYTE_SPACE) s = wsi_pkg::SYM_SPACE;
    else if (b == wsi_pkg::BYTE_TAB) s = wsi_pkg::SYM_TAB;
    else if (b == wsi_pkg::BYTE_LF) s = wsi_pkg::SYM_LF;
    else return;

    // Inside a push argument: sign first, then binary digits, LF ends it.
    if (arg_active) begin
      if (s == wsi_pkg::SYM_LF) begin
        v = arg_neg ? 32'd0 - arg_mag : arg_mag;
        clear_decoder();
        if (stack_fill >= DEPTH) begin
          results_due.push_back('{kind: wsi_pkg::KIND_OVER, value: 32'd0});
        end else begin
          stack_mem[stack_fill] = v;
          stack_fill++;
        end
      end else if (!arg_sign_seen) begin
        arg_sign_seen = 1'b1;
        arg_neg       = (s == wsi_pkg::SYM_TAB);
      end else begin
        arg_mag = {arg_mag[30:0], s == wsi_pkg::SYM_TAB};
      end
      return;
    end

    // Command symbols: newest in the low two bits.
    cmd_sym = {cmd_sym[13:0], s};
    cmd_len++;
    if (cmd_len == wsi_pkg::LEN_PUSH && cmd_sym == wsi_pkg::CODE_PUSH) begin
      clear_decoder();
      arg_active = 1'b1;
    end else if (cmd_len == wsi_pkg::LEN_OUT &&
                 (cmd_sym == wsi_pkg::CODE_OUT_NUM || cmd_sym == wsi_pkg::CODE_OUT_CHR)) begin
      if (stack_fill == 0) begin
        results_due.push_back('{kind: wsi_pkg::KIND_UNDER, value: 32'd0});
      end else begin
        stack_fill--;
        v = stack_mem[stack_fill];
        if (cmd_sym == wsi_pkg::CODE_OUT_CHR)
          results_due.push_back('{kind: wsi_pkg::KIND_CHAR, value: {24'd0, v[7:0]}});
        else
          results_due.push_back('{kind: wsi_pkg::KIND_NUMBER, value: v});
      end
      clear_decoder();
    end else if (cmd_len >= MAX_SYMS) begin
      clear_decoder();
      results_due.push_back('{kind: wsi_pkg::KIND_UNKNOWN, value: 32'd0});
    end
  endtask

  // Driver: hold each item until accepted, then offer the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_src_byte <= 8'd0;
      clear_decoder();
      stack_fill = 0;
    end else begin
      if (in_valid && in_ready) begin
        interpret_byte(in_src_byte);
        n_bytes++;
      end
      if (!in_valid || in_ready) begin
        if (src_q.size() > 0 && $urandom_range(0, 99) >= idle_pct()) begin
          in_valid    <= 1'b1;
          in_src_byte <= src_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest one owed.
  ws_result_t due;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: out_kind %0d, out_value %0d", out_kind, out_value);
          n_errors++;
        end else begin
          due = results_due.pop_front();
          if (out_kind !== due.kind) begin
            $error("out_kind mismatch: expected %0d, actual %0d", due.kind, out_kind);
            n_errors++;
          end
          if (out_value !== due.value) begin
            $error("out_value mismatch: expected %0d, actual %0d", $signed(due.value),
                   out_value);
            n_errors++;
          end
          kind_seen[int'(due.kind)]++;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= idle_pct());
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    cyc_cnt++;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    est_depth   = 0;
    comment_pct = 0;

    // Directed part: pops on an empty stack, comment bytes at the extremes and next to symbol codes.
    gen_pop(1'b0);
    gen_pop(1'b1);
    src_q.push_back(8'd0);
    src_q.push_back(8'd255);
    src_q.push_back(8'd8);
    src_q.push_back(8'd11);
    src_q.push_back(8'd31);
    src_q.push_back(8'd33);
    // Empty argument pushes zero.
    gen_push(1'b0, 1'b0, 0, '0);
    gen_pop(1'b0);
    // Largest positive, most negative, minus one and a positive 32-digit value.
    gen_push(1'b1, 1'b0, 31, 64'h7FFF_FFFF);
    gen_push(1'b1, 1'b1, 32, 64'h8000_0000);
    gen_push(1'b1, 1'b1, 1, 64'h1);
    gen_push(1'b1, 1'b0, 32, 64'h1234_56A5);
    // Long argument that wraps past 32 bits, and a sign with no digits.
    gen_push(1'b1, 1'b0, 40, 64'hA5_F0E1_D2C3);
    gen_push(1'b1, 1'b1, 0, '0);
    gen_pop(1'b1);
    gen_pop(1'b1);
    gen_pop(1'b0);
    gen_pop(1'b1);
    gen_pop(1'b0);
    // Comments interleaved with symbols.
    comment_pct = 50;
    gen_pop(1'b0);
    gen_pop(1'b1);
    comment_pct = 0;
    // Symbol strings that match no command.
    put_sym(wsi_pkg::BYTE_TAB); put_sym(wsi_pkg::BYTE_TAB);
    put_sym(wsi_pkg::BYTE_TAB); put_sym(wsi_pkg::BYTE_TAB);
    put_sym(wsi_pkg::BYTE_LF); put_sym(wsi_pkg::BYTE_LF);
    put_sym(wsi_pkg::BYTE_LF); put_sym(wsi_pkg::BYTE_LF);
    put_sym(wsi_pkg::BYTE_SPACE); put_sym(wsi_pkg::BYTE_TAB);
    put_sym(wsi_pkg::BYTE_LF); put_sym(wsi_pkg::BYTE_SPACE);
    put_sym(wsi_pkg::BYTE_TAB); put_sym(wsi_pkg::BYTE_LF);
    put_sym(wsi_pkg::BYTE_SPACE); put_sym(wsi_pkg::BYTE_LF);

    // Random mix of commands with noise and broken sequences.
    comment_pct = 6;
    est_depth = 0;
    while (n_syms < MIX_SYMS) gen_random_command(est_depth > 24 ? 25 : 0);

    // Fill the stack with the shortest pushes, then push past full to provoke overflows.
    comment_pct = 2;
    while (est_depth < DEPTH) gen_push(1'b0, 1'b0, 0, '0);
    repeat (6) gen_random_push();

    // Pop down through some values of the filled stack.
    comment_pct = 6;
    repeat (20) gen_random_command(30);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every byte to be taken and every result to arrive.
    while (src_q.size() > 0 || in_valid || results_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes, %0d of them symbols, through a full stack and back.",
             n_bytes, n_syms);
    $display("Results: %0d number, %0d character, %0d underflow, %0d overflow, %0d unknown.",
             kind_seen[int'(wsi_pkg::KIND_NUMBER)], kind_seen[int'(wsi_pkg::KIND_CHAR)],
             kind_seen[int'(wsi_pkg::KIND_UNDER)], kind_seen[int'(wsi_pkg::KIND_OVER)],
             kind_seen[int'(wsi_pkg::KIND_UNKNOWN)]);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
